// ===== hdl/rrts_pkg.sv =====
// Shared types and constants for the round-robin tick scheduler.
package rrts_pkg;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [7:0] QUANTUM_RESET = 8'd2;

    typedef struct packed {
        logic        action;
        logic [7:0]  task_id;
        logic [15:0] burst_length;
    } in_t;

    typedef struct packed {
        logic        ran;
        logic [7:0]  running_task;
        logic        finished;
        logic [31:0] finish_time;
        logic        dropped;
    } out_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] remaining;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } state_t;

endpackage

// ===== hdl/rrts_queue_ram.sv =====
// Ready-queue storage: one write port, one registered read port.
module rrts_queue_ram #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  rrts_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output rrts_pkg::entry_t     rd_data
);

    rrts_pkg::entry_t mem [QUEUE_DEPTH];
    rrts_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rrts_core.sv =====
// Scheduler control: queue pointers, current task, clock and request sequencing.
module rrts_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rrts_pkg::in_t     s_data,
    output logic              res_valid,
    input  logic              res_ready,
    output rrts_pkg::out_t    res_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    rrts_pkg::state_t state_reg, state_next;
    rrts_pkg::in_t    req_reg;
    logic             cur_valid_reg;
    logic [7:0]       cur_id_reg;
    logic [15:0]      cur_left_reg;
    logic [7:0]       slice_reg;
    logic [31:0]      clock_reg;
    logic [7:0]       quantum_reg;
    logic [AW-1:0]    head_reg, tail_reg;
    logic [CW-1:0]    count_reg;

    logic             accept, rd_en, full, empty, commit;
    logic             is_tick, ran, push_en, slice_over;
    logic [7:0]       quantum, slice_inc;
    logic [15:0]      left_dec;
    logic [31:0]      clock_inc;
    rrts_pkg::entry_t push_data, rd_data;

    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign accept = s_valid && s_ready;
    assign rd_en  = accept && (s_data.action == rrts_pkg::ACT_TICK) && !cur_valid_reg && !empty;
    assign commit = (state_reg == rrts_pkg::ST_EXEC) && res_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = rd_en ? rrts_pkg::ST_FETCH : rrts_pkg::ST_EXEC;
                end
            end
            rrts_pkg::ST_FETCH: begin
                state_next = rrts_pkg::ST_EXEC;
            end
            rrts_pkg::ST_EXEC: begin
                if (res_ready) begin
                    state_next = rrts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            rrts_pkg::ST_IDLE:  s_ready   = 1'b1;
            rrts_pkg::ST_FETCH: s_ready   = 1'b0;
            rrts_pkg::ST_EXEC:  res_valid = 1'b1;
            default: begin
                s_ready   = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        is_tick    = (req_reg.action == rrts_pkg::ACT_TICK);
        quantum    = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
        left_dec   = (cur_left_reg != 16'd0) ? cur_left_reg - 16'd1 : 16'd0;
        slice_inc  = (slice_reg != 8'hFF) ? slice_reg + 8'd1 : slice_reg;
        clock_inc  = clock_reg + 32'd1;
        ran        = is_tick && cur_valid_reg;
        slice_over = (slice_inc >= quantum);

        res_data.ran          = ran;
        res_data.running_task = ran ? cur_id_reg : 8'd0;
        res_data.finished     = ran && (left_dec == 16'd0);
        res_data.finish_time  = is_tick ? clock_inc : clock_reg;
        res_data.dropped      = !is_tick && full;

        push_en = !full && ((!is_tick) || (ran && (left_dec != 16'd0) && slice_over));
        if (is_tick) begin
            push_data.id        = cur_id_reg;
            push_data.remaining = left_dec;
        end else begin
            push_data.id        = req_reg.task_id;
            push_data.remaining = req_reg.burst_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rrts_pkg::ST_IDLE;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= 8'd0;
            cur_left_reg  <= 16'd0;
            slice_reg     <= 8'd0;
            clock_reg     <= 32'd0;
            quantum_reg   <= rrts_pkg::QUANTUM_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            if (state_reg == rrts_pkg::ST_FETCH) begin
                cur_valid_reg <= 1'b1;
                cur_id_reg    <= rd_data.id;
                cur_left_reg  <= rd_data.remaining;
                slice_reg     <= 8'd0;
                head_reg      <= (head_reg == LAST_PTR) ? '0 : head_reg + AW'(1);
                count_reg     <= count_reg - CW'(1);
            end
            if (commit) begin
                if (is_tick) begin
                    clock_reg <= clock_inc;
                end
                if (ran) begin
                    cur_left_reg <= left_dec;
                    if (left_dec == 16'd0) begin
                        cur_valid_reg <= 1'b0;
                        slice_reg     <= 8'd0;
                    end else if (slice_over) begin
                        slice_reg <= 8'd0;
                        if (!full) begin
                            cur_valid_reg <= 1'b0;
                        end
                    end else begin
                        slice_reg <= slice_inc;
                    end
                end
                if (push_en) begin
                    tail_reg  <= (tail_reg == LAST_PTR) ? '0 : tail_reg + AW'(1);
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    rrts_queue_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (commit && push_en),
        .wr_addr (tail_reg),
        .wr_data (push_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/round_robin_tick_scheduler_unit.sv =====
// Top level of the round-robin tick scheduler with its output register.
//
// Requests arrive on s_valid/s_ready/s_data: an arrive request queues a task,
// a tick request runs the current task for one time unit. Every request gives
// exactly one result on m_valid/m_ready/m_data, in order.
// cfg_wr_en/cfg_wr_data write the time quantum; write it only while idle.
// A request goes from acceptance through ST_EXEC to the output register, and
// through ST_FETCH first when a tick must fetch a new task from the queue head:
// the queue memory has a registered read port. One request is in flight at a
// time, so a new request is accepted only once the output register takes the last result.
// The output register lets the next request be accepted while a result waits;
// when the receiver stalls, a finished request holds in its last stage until
// the output register frees, and no further request is accepted.
// Reset (aresetn low, synchronous) empties the queue, clears the current task
// and the clock, and sets the quantum to 2. The queue memory needs no clearing.
module round_robin_tick_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rrts_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rrts_pkg::out_t    m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);

    logic           res_valid, res_ready;
    rrts_pkg::out_t res_data;
    logic           out_valid_reg;
    rrts_pkg::out_t out_data_reg;

    rrts_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result lost while output register busy");

    a_no_result_with_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && s_ready))
        else $error("new request taken before result delivered");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
